[hdl/psdf_pkg.sv]
package psdf_pkg;

    localparam int unsigned INDEX_W = 6;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_POSITION_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_COUNT = 2'd2;

    localparam logic [LIMIT_W-1:0] MAX_POSITION_STEP_RST = 31'd6554;
    localparam logic [LIMIT_W-1:0] MAX_SPEED_RST = 31'd3276800;
    localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT_RST = 8'd3;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_FAULT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_TOP = 8'hFF;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] last_position;
        logic [COUNT_W-1:0] spike_count;
    } entry_t;

endpackage

[hdl/psdf_cfg_if.sv]
interface psdf_cfg_if;
    logic valid;
    logic ready;
    logic [psdf_pkg::CFG_ADDR_W-1:0] index;
    logic [psdf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/psdf_sample_if.sv]
interface psdf_sample_if;
    logic valid;
    logic ready;
    logic [psdf_pkg::INDEX_W-1:0] motor_index;
    logic signed [psdf_pkg::SAMPLE_W-1:0] position;
    logic signed [psdf_pkg::SAMPLE_W-1:0] velocity;

    modport source (output valid, output motor_index, output position, output velocity,
                    input ready);
    modport sink (input valid, input motor_index, input position, input velocity,
                  output ready);
endinterface

[hdl/psdf_result_if.sv]
interface psdf_result_if;
    logic valid;
    logic ready;
    logic [psdf_pkg::INDEX_W-1:0] out_motor_index;
    logic action;
    logic signed [psdf_pkg::SAMPLE_W-1:0] out_position;
    logic signed [psdf_pkg::SAMPLE_W-1:0] out_velocity;

    modport source (output valid, output out_motor_index, output action,
                    output out_position, output out_velocity, input ready);
    modport sink (input valid, input out_motor_index, input action,
                  input out_position, input out_velocity, output ready);
endinterface

[hdl/per_channel_spike_debounce_filter_top.sv]
// Channel   Dir  Payload                                            Transaction
// cfg       in   index[1:0], data[30:0]                             valid & ready
// samples   in   motor_index, position, velocity                    valid & ready
// results   out  out_motor_index, action, out_position, out_velocity valid & ready
//
// One sample per cycle sustained while results are taken; a sample is registered in stage 1, its result by stage 2.
// Stage 1 reads the channel entry from a one-port-read, one-port-write memory;
// stage 2 decides and writes back, with a forward of the write just made.
// Seen flags are flip-flops cleared by rst_n; memory contents need no reset.
// A stalled result holds stage 2 and, through it, the sample channel.
// Samples whose index is out of range are taken and dropped.
module per_channel_spike_debounce_filter_top #(
    parameter int unsigned NUM_CHANNELS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    psdf_cfg_if.sink         cfg,
    psdf_sample_if.sink      samples,
    psdf_result_if.source    results
);

    localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    psdf_pkg::entry_t mem [NUM_CHANNELS];

    logic [psdf_pkg::LIMIT_W-1:0] max_step_reg;
    logic [psdf_pkg::LIMIT_W-1:0] max_speed_reg;
    logic [psdf_pkg::COUNT_W-1:0] debounce_reg;

    logic [NUM_CHANNELS-1:0] seen_reg;

    logic s1_valid_reg;
    logic [psdf_pkg::INDEX_W-1:0] s1_index_reg;
    logic [psdf_pkg::SAMPLE_W-1:0] s1_pos_reg;
    logic [psdf_pkg::SAMPLE_W-1:0] s1_vel_reg;
    psdf_pkg::entry_t rd_data_reg;
    logic fwd_hit_reg;
    psdf_pkg::entry_t fwd_data_reg;

    logic out_valid_reg;
    logic [psdf_pkg::INDEX_W-1:0] out_index_reg;
    logic out_action_reg;
    logic [psdf_pkg::SAMPLE_W-1:0] out_pos_reg;
    logic [psdf_pkg::SAMPLE_W-1:0] out_vel_reg;

    logic accept;
    logic in_range;
    logic s1_advance;
    logic s1_fire;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] s1_addr;

    psdf_pkg::entry_t cur_entry;
    psdf_pkg::entry_t wr_data;
    logic seen;
    logic [psdf_pkg::SAMPLE_W:0] pos_diff;
    logic [psdf_pkg::SAMPLE_W:0] step_mag;
    logic [psdf_pkg::SAMPLE_W-1:0] vel_mag;
    logic spike;
    logic [psdf_pkg::COUNT_W-1:0] count_inc;
    logic fault;
    logic res_action;
    logic [psdf_pkg::SAMPLE_W-1:0] res_pos;
    logic [psdf_pkg::SAMPLE_W-1:0] res_vel;

    assign cfg.ready = 1'b1;

    assign in_addr = samples.motor_index[AW-1:0];
    assign s1_addr = s1_index_reg[AW-1:0];
    assign in_range = ({1'b0, samples.motor_index} < (psdf_pkg::INDEX_W + 1)'(NUM_CHANNELS));

    assign s1_advance = !out_valid_reg || results.ready;
    assign s1_fire = s1_valid_reg && s1_advance;
    assign samples.ready = !s1_valid_reg || s1_advance;
    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        cur_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        seen = seen_reg[s1_addr];
        pos_diff = {s1_pos_reg[psdf_pkg::SAMPLE_W-1], s1_pos_reg}
                 - {cur_entry.last_position[psdf_pkg::SAMPLE_W-1], cur_entry.last_position};
        step_mag = pos_diff[psdf_pkg::SAMPLE_W] ? (~pos_diff + 1'b1) : pos_diff;
        vel_mag = s1_vel_reg[psdf_pkg::SAMPLE_W-1] ? (~s1_vel_reg + 1'b1) : s1_vel_reg;
        spike = (step_mag > {2'b00, max_step_reg}) || (vel_mag > {1'b0, max_speed_reg});
        count_inc = (cur_entry.spike_count == psdf_pkg::COUNT_TOP)
                  ? cur_entry.spike_count : cur_entry.spike_count + 1'b1;
        fault = (count_inc >= debounce_reg);

        res_action = psdf_pkg::ACTION_SAMPLE;
        res_pos = s1_pos_reg;
        res_vel = s1_vel_reg;
        wr_data.last_position = s1_pos_reg;
        wr_data.spike_count = '0;

        if (seen && spike)
        begin
            wr_data.last_position = cur_entry.last_position;
            wr_data.spike_count = count_inc;
            if (fault)
            begin
                res_action = psdf_pkg::ACTION_FAULT;
                res_pos = '0;
                res_vel = '0;
            end
            else
            begin
                res_pos = cur_entry.last_position;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            mem[s1_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= mem[in_addr];
            fwd_data_reg <= wr_data;
            s1_index_reg <= samples.motor_index;
            s1_pos_reg <= samples.position;
            s1_vel_reg <= samples.velocity;
        end
        if (s1_fire)
        begin
            out_index_reg <= s1_index_reg;
            out_action_reg <= res_action;
            out_pos_reg <= res_pos;
            out_vel_reg <= res_vel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= psdf_pkg::MAX_POSITION_STEP_RST;
            max_speed_reg <= psdf_pkg::MAX_SPEED_RST;
            debounce_reg <= psdf_pkg::DEBOUNCE_COUNT_RST;
            seen_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    psdf_pkg::CFG_MAX_POSITION_STEP: max_step_reg <= cfg.data;
                    psdf_pkg::CFG_MAX_SPEED: max_speed_reg <= cfg.data;
                    psdf_pkg::CFG_DEBOUNCE_COUNT: debounce_reg <= cfg.data[psdf_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (s1_fire)
            begin
                seen_reg[s1_addr] <= 1'b1;
            end

            if (accept)
            begin
                s1_valid_reg <= in_range;
                fwd_hit_reg <= s1_fire && (s1_addr == in_addr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.out_motor_index = out_index_reg;
    assign results.action = out_action_reg;
    assign results.out_position = out_pos_reg;
    assign results.out_velocity = out_vel_reg;

endmodule

[hdl/psdf_checker.sv]
module psdf_checker #(
    parameter int unsigned NUM_CHANNELS = 64
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic [psdf_pkg::INDEX_W-1:0]         res_index,
    input logic                                 res_action,
    input logic [psdf_pkg::SAMPLE_W-1:0]        res_position,
    input logic [psdf_pkg::SAMPLE_W-1:0]        res_velocity
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_index) && $stable(res_action)
            && $stable(res_position) && $stable(res_velocity))
        else $error("result changed while stalled");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_action == psdf_pkg::ACTION_FAULT) |->
            (res_position == '0) && (res_velocity == '0))
        else $error("fault result carries sample data");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, res_index} < (psdf_pkg::INDEX_W + 1)'(NUM_CHANNELS)))
        else $error("result for channel out of range");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

endmodule

bind per_channel_spike_debounce_filter_top psdf_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_psdf_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(results.valid),
    .res_ready(results.ready),
    .res_index(results.out_motor_index),
    .res_action(results.action),
    .res_position(results.out_position),
    .res_velocity(results.out_velocity)
);
